// File: hdl/rsdp_pkg.sv
// ----------------------------------------------------------------------------
// rsdp_pkg
// shared codes and controller/datapath signal groups for the ring stack
// ----------------------------------------------------------------------------
package rsdp_pkg;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_RUN  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic start;
        logic flag_full;
        logic flag_empty;
        logic push;
        logic load_run;
        logic drop;
        logic take_rd;
        logic zero_top;
        logic out_load;
    } ctrl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       empty;
        logic       full;
        logic       last;
        logic       match;
        logic       out_free;
    } stat_t;

endpackage

// File: hdl/rsdp_cmd_if.sv
// ----------------------------------------------------------------------------
// rsdp_cmd_if
// command channel: valid/ready with command code and push value
// ----------------------------------------------------------------------------
interface rsdp_cmd_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   command;
    logic signed [DATA_WIDTH-1:0] push_value;

    modport source (output valid, output command, output push_value, input ready);
    modport sink   (input valid, input command, input push_value, output ready);
endinterface

// File: hdl/rsdp_rsp_if.sv
// ----------------------------------------------------------------------------
// rsdp_rsp_if
// result channel: valid/ready with status, counts and top value
// ----------------------------------------------------------------------------
interface rsdp_rsp_if #(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 7
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [CNT_W-1:0]             element_count;
    logic signed [DATA_WIDTH-1:0] top_value;
    logic [CNT_W-1:0]             removed_count;

    modport source (output valid, output status, output element_count,
                    output top_value, output removed_count, input ready);
    modport sink   (input valid, input status, input element_count,
                    input top_value, input removed_count, output ready);
endinterface

// File: hdl/rsdp_datapath.sv
// ----------------------------------------------------------------------------
// rsdp_datapath
// element memory, top pointer, count, run value and result register
// ----------------------------------------------------------------------------
module rsdp_datapath #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 6,
    parameter int CW         = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            command,
    input  logic [DATA_WIDTH-1:0] push_value,
    input  rsdp_pkg::ctrl_t       ctrl,
    output rsdp_pkg::stat_t       stat,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [1:0]            out_status,
    output logic [CW-1:0]         out_count,
    output logic [DATA_WIDTH-1:0] out_top,
    output logic [CW-1:0]         out_removed
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [AW-1:0]         top_reg, top_next, top_dec, top_inc;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         removed_reg, removed_next;
    logic [1:0]            status_reg, status_next;
    logic [DATA_WIDTH-1:0] top_val_reg, top_val_next;
    logic [DATA_WIDTH-1:0] run_val_reg;
    logic                  out_valid_reg;
    logic [1:0]            out_status_reg;
    logic [CW-1:0]         out_count_reg;
    logic [DATA_WIDTH-1:0] out_top_reg;
    logic [CW-1:0]         out_removed_reg;

    assign top_dec = (top_reg == '0) ? AW'(DEPTH - 1) : top_reg - AW'(1);
    assign top_inc = (top_reg == AW'(DEPTH - 1)) ? '0 : top_reg + AW'(1);

    always_comb
    begin
        top_next     = top_reg;
        count_next   = count_reg;
        removed_next = ctrl.start ? '0 : removed_reg;
        status_next  = status_reg;
        top_val_next = top_val_reg;
        if (ctrl.start)
        begin
            if (ctrl.flag_full)
                status_next = rsdp_pkg::STAT_FULL;
            else if (ctrl.flag_empty)
                status_next = rsdp_pkg::STAT_EMPTY;
            else
                status_next = rsdp_pkg::STAT_OK;
        end
        if (ctrl.push)
        begin
            top_next     = top_dec;
            count_next   = count_reg + CW'(1);
            top_val_next = push_value;
        end
        if (ctrl.drop)
        begin
            top_next     = top_inc;
            count_next   = count_reg - CW'(1);
            removed_next = removed_next + CW'(1);
        end
        if (ctrl.take_rd)
            top_val_next = rd_data_reg;
        if (ctrl.zero_top)
            top_val_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
            mem[top_dec] <= push_value;
        rd_data_reg <= mem[top_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_run)
            run_val_reg <= top_val_reg;
        if (ctrl.out_load)
        begin
            out_status_reg  <= status_reg;
            out_count_reg   <= count_reg;
            out_top_reg     <= top_val_reg;
            out_removed_reg <= removed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg       <= '0;
            count_reg     <= '0;
            removed_reg   <= '0;
            status_reg    <= rsdp_pkg::STAT_OK;
            top_val_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            top_reg     <= top_next;
            count_reg   <= count_next;
            removed_reg <= removed_next;
            status_reg  <= status_next;
            top_val_reg <= top_val_next;
            if (ctrl.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign stat.cmd      = command;
    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == CW'(DEPTH));
    assign stat.last     = (count_reg == CW'(1));
    assign stat.match    = (rd_data_reg == run_val_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_count   = out_count_reg;
    assign out_top     = out_top_reg;
    assign out_removed = out_removed_reg;

endmodule

// File: hdl/rsdp_ctrl.sv
// ----------------------------------------------------------------------------
// rsdp_ctrl
// command sequencer: accepts a command, walks pops, hands off the result
// ----------------------------------------------------------------------------
module rsdp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rsdp_pkg::stat_t stat,
    output rsdp_pkg::ctrl_t ctrl
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   run_reg, run_next;

    always_comb
    begin
        ctrl       = '0;
        state_next = state_reg;
        run_next   = run_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.start = 1'b1;
                    state_next = ST_DONE;
                    run_next   = (stat.cmd == rsdp_pkg::CMD_RUN);
                    if (stat.cmd == rsdp_pkg::CMD_PUSH)
                    begin
                        if (stat.full)
                            ctrl.flag_full = 1'b1;
                        else
                            ctrl.push = 1'b1;
                    end
                    else if (stat.cmd inside {rsdp_pkg::CMD_POP, rsdp_pkg::CMD_RUN})
                    begin
                        if (stat.empty)
                            ctrl.flag_empty = 1'b1;
                        else
                        begin
                            ctrl.drop     = 1'b1;
                            ctrl.load_run = 1'b1;
                            if (stat.last)
                                ctrl.zero_top = 1'b1;
                            else
                                state_next = ST_READ;
                        end
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (run_reg && stat.match)
                begin
                    ctrl.drop = 1'b1;
                    if (stat.last)
                    begin
                        ctrl.zero_top = 1'b1;
                        state_next    = ST_DONE;
                    end
                    else
                        state_next = ST_READ;
                end
                else
                begin
                    ctrl.take_rd = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            run_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            run_reg   <= run_next;
        end
    end

endmodule

// File: hdl/ring_stack_with_dup_pop_unit.sv
// ----------------------------------------------------------------------------
// ring_stack_with_dup_pop_unit
// lifo stack in a ring memory with push, pop and pop of an equal run
// ----------------------------------------------------------------------------
// request channel carries a command (push, pop, pop run) and a push value;
// response channel returns one result per command: status, element count,
// top value (zero when empty) and the number of elements removed.
// one command is in work at a time; request.ready is high while idle.
// push, a dropped push, an ignored pop, a pop of the last element and the
// unused code go straight to the result. any other pop reads the new top
// through the read and check states; a run pop repeats read and check,
// dropping each equal element, until one differs or the stack empties.
// each step below the top is one registered read of the element memory
// and one compare.
// the result sits in an output register, so the next command is taken
// while a result waits; a stalled receiver holds the following result
// back until the register frees.
// reset clears pointer, count and the output valid flag; the element
// memory is not cleared, only entries that were pushed are read.
// ----------------------------------------------------------------------------
module ring_stack_with_dup_pop_unit #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    rsdp_cmd_if.sink   request,
    rsdp_rsp_if.source response
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    rsdp_pkg::ctrl_t       ctrl;
    rsdp_pkg::stat_t       stat;
    logic [DATA_WIDTH-1:0] out_top;

    rsdp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    rsdp_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW),
        .CW         (CW)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .command     (request.command),
        .push_value  (request.push_value),
        .ctrl        (ctrl),
        .stat        (stat),
        .out_ready   (response.ready),
        .out_valid   (response.valid),
        .out_status  (response.status),
        .out_count   (response.element_count),
        .out_top     (out_top),
        .out_removed (response.removed_count)
    );

    assign response.top_value = out_top;

endmodule
